// ===== rtl/cre_pkg.sv =====
package cre_pkg;

    localparam logic [7:0] END_LINE_CODE = 8'd255;
    localparam logic [7:0] FILL_CODE     = 8'd254;
    localparam logic [7:0] SKIP_CODE     = 8'd253;
    localparam logic [7:0] COPY_CODE     = 8'd252;
    localparam logic [7:0] ESCAPE_CODE   = 8'd251;

    localparam int MAX_COORD_DEFAULT = 1023;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
    localparam logic [1:0] REG_CLIP_RIGHT  = 2'd1;
    localparam logic [1:0] REG_CLIP_TOP    = 2'd2;
    localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;

    localparam logic [1:0] OP_SPAN = 2'd0;
    localparam logic [1:0] OP_SKIP = 2'd1;
    localparam logic [1:0] OP_EOL  = 2'd2;

    typedef struct packed {
        logic [1:0] code;
        logic [8:0] count;
        logic [7:0] pixel;
    } op_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [10:0] data;
    } cfg_wr_t;

endpackage

// ===== rtl/cre_front.sv =====
module cre_front
    import cre_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] stream_byte,
    output logic       push,
    output op_t        push_op
);

    localparam logic [2:0] PH_CODE   = 3'd0;
    localparam logic [2:0] PH_COUNT  = 3'd1;
    localparam logic [2:0] PH_COLOUR = 3'd2;
    localparam logic [2:0] PH_SKIP   = 3'd3;
    localparam logic [2:0] PH_COPY   = 3'd4;
    localparam logic [2:0] PH_ESCAPE = 3'd5;

    logic [2:0] phase_reg, phase_next;
    logic       fill_reg, fill_next;
    logic [8:0] run_left_reg, run_left_next;
    logic [8:0] byte_plus_one;
    logic [8:0] run_dec;

    assign byte_plus_one = {1'b0, stream_byte} + 9'd1;
    assign run_dec       = (run_left_reg != 9'd0) ? run_left_reg - 9'd1 : 9'd0;

    always_comb
    begin
        phase_next    = phase_reg;
        fill_next     = fill_reg;
        run_left_next = run_left_reg;
        push          = 1'b0;
        push_op.code  = OP_SPAN;
        push_op.count = 9'd1;
        push_op.pixel = stream_byte;
        if (accept)
        begin
            unique case (phase_reg)
                PH_CODE:
                begin
                    priority if (stream_byte == END_LINE_CODE)
                    begin
                        push         = 1'b1;
                        push_op.code = OP_EOL;
                    end
                    else if (stream_byte == FILL_CODE)
                    begin
                        fill_next  = 1'b1;
                        phase_next = PH_COUNT;
                    end
                    else if (stream_byte == SKIP_CODE)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else if (stream_byte == COPY_CODE)
                    begin
                        fill_next  = 1'b0;
                        phase_next = PH_COUNT;
                    end
                    else if (stream_byte == ESCAPE_CODE)
                    begin
                        phase_next = PH_ESCAPE;
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                end
                PH_COUNT:
                begin
                    run_left_next = byte_plus_one;
                    phase_next    = fill_reg ? PH_COLOUR : PH_COPY;
                end
                PH_COLOUR:
                begin
                    push          = 1'b1;
                    push_op.count = run_left_reg;
                    run_left_next = 9'd0;
                    phase_next    = PH_CODE;
                end
                PH_SKIP:
                begin
                    push          = 1'b1;
                    push_op.code  = OP_SKIP;
                    push_op.count = byte_plus_one;
                    phase_next    = PH_CODE;
                end
                PH_COPY:
                begin
                    push          = 1'b1;
                    run_left_next = run_dec;
                    if (run_dec == 9'd0)
                    begin
                        phase_next = PH_CODE;
                    end
                end
                PH_ESCAPE:
                begin
                    push       = 1'b1;
                    phase_next = PH_CODE;
                end
                default:
                begin
                    phase_next = PH_CODE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_CODE;
            fill_reg     <= 1'b0;
            run_left_reg <= 9'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            fill_reg     <= fill_next;
            run_left_reg <= run_left_next;
        end
    end

endmodule

// ===== rtl/cre_queue.sv =====
module cre_queue
    import cre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output op_t  pop_op
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    op_t            entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0] count_reg, count_next;
    logic           do_push, do_pop;

    assign full     = (count_reg == CNW'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_op   = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/cre_back.sv =====
module cre_back
    import cre_pkg::*;
#(
    parameter int MAX_COORD = MAX_COORD_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_wr_t    cfg_wr,
    input  logic       q_nonempty,
    input  op_t        q_op,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [9:0] col,
    output logic [9:0] row,
    output logic [8:0] length,
    output logic [7:0] pixel
);

    localparam int CW  = $clog2(MAX_COORD + 2);
    localparam int RW  = $clog2(MAX_COORD + 1);
    localparam int SW  = ((CW > 11) ? CW : 11) + 1;
    localparam int RSW = (RW > 11) ? RW : 11;

    logic [9:0]    clip_left_reg;
    logic [10:0]   clip_right_reg;
    logic [9:0]    clip_top_reg;
    logic [10:0]   clip_bottom_reg;

    logic [CW-1:0] column_reg, column_next;
    logic [RW-1:0] line_row_reg, line_row_next;

    logic          out_valid_reg, out_valid_next;
    logic          kind_reg;
    logic [9:0]    col_reg;
    logic [9:0]    row_reg;
    logic [8:0]    length_reg;
    logic [7:0]    pixel_reg;

    logic [SW-1:0]  col_ext, sum, col_limit, col_sat, lo, hi_a, hi_b, span_len;
    logic [RSW-1:0] row_ext;
    logic           row_ok, visible, load_out;

    assign q_pop     = q_nonempty && (!out_valid_reg || !out_stall);
    assign col_ext   = SW'(column_reg);
    assign sum       = col_ext + SW'(q_op.count);
    assign col_limit = SW'(MAX_COORD) + SW'(1);
    assign col_sat   = (sum > col_limit) ? col_limit : sum;
    assign lo        = (col_ext < SW'(clip_left_reg)) ? SW'(clip_left_reg) : col_ext;
    assign hi_a      = (sum > SW'(clip_right_reg)) ? SW'(clip_right_reg) : sum;
    assign hi_b      = (hi_a > col_limit) ? col_limit : hi_a;
    assign span_len  = hi_b - lo;
    assign row_ext   = RSW'(line_row_reg);
    assign row_ok    = (row_ext >= RSW'(clip_top_reg)) && (row_ext < RSW'(clip_bottom_reg));
    assign visible   = row_ok && (hi_b > lo);

    always_comb
    begin
        column_next    = column_reg;
        line_row_next  = line_row_reg;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        if (q_pop)
        begin
            unique case (q_op.code)
                OP_EOL:
                begin
                    load_out    = 1'b1;
                    column_next = '0;
                    if (line_row_reg < RW'(MAX_COORD))
                    begin
                        line_row_next = line_row_reg + RW'(1);
                    end
                end
                OP_SPAN:
                begin
                    load_out    = visible;
                    column_next = CW'(col_sat);
                end
                OP_SKIP:
                begin
                    column_next = CW'(col_sat);
                end
                default:
                begin
                    column_next = column_reg;
                end
            endcase
            if (load_out)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= 10'd0;
            clip_right_reg  <= 11'd1024;
            clip_top_reg    <= 10'd0;
            clip_bottom_reg <= 11'd1024;
            column_reg      <= '0;
            line_row_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr.valid)
            begin
                unique case (cfg_wr.index)
                    REG_CLIP_LEFT:   clip_left_reg   <= cfg_wr.data[9:0];
                    REG_CLIP_RIGHT:  clip_right_reg  <= cfg_wr.data;
                    REG_CLIP_TOP:    clip_top_reg    <= cfg_wr.data[9:0];
                    REG_CLIP_BOTTOM: clip_bottom_reg <= cfg_wr.data;
                    default:         clip_left_reg   <= clip_left_reg;
                endcase
            end
            column_reg    <= column_next;
            line_row_reg  <= line_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (q_op.code == OP_EOL)
            begin
                kind_reg   <= 1'b1;
                col_reg    <= 10'd0;
                length_reg <= 9'd0;
                pixel_reg  <= 8'd0;
            end
            else
            begin
                kind_reg   <= 1'b0;
                col_reg    <= lo[9:0];
                length_reg <= span_len[8:0];
                pixel_reg  <= q_op.pixel;
            end
            row_reg <= row_ext[9:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign col       = col_reg;
    assign row       = row_reg;
    assign length    = length_reg;
    assign pixel     = pixel_reg;

endmodule

// ===== rtl/clipped_rle_sprite_decoder.sv =====
// Each result passes through the op queue and then the output register, which holds it.
// Throughput: one stream byte per cycle while in_stall is low; the decode front and the
// clip/span back end run on their own, joined by a two-entry op queue.
// Reset (rst_n low, asynchronous): decoder expects a code byte, column and row are zero,
// the clip window opens to the full 1024 x 1024 area and the queue and output are empty.
module clipped_rle_sprite_decoder
    import cre_pkg::*;
#(
    parameter int MAX_COORD = MAX_COORD_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [9:0]  col,
    output logic [9:0]  row,
    output logic [8:0]  length,
    output logic [7:0]  pixel,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    logic    accept;
    logic    push;
    op_t     push_op;
    logic    q_full;
    logic    q_pop;
    logic    q_nonempty;
    op_t     q_op;
    cfg_wr_t cfg_wr;

    assign in_stall     = q_full;
    assign accept       = in_valid && !q_full;
    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    cre_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream_byte),
        .push        (push),
        .push_op     (push_op)
    );

    cre_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .pop_op   (q_op)
    );

    cre_back #(
        .MAX_COORD (MAX_COORD)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .q_nonempty (q_nonempty),
        .q_op       (q_op),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .col        (col),
        .row        (row),
        .length     (length),
        .pixel      (pixel)
    );

endmodule
